// ===== rtl/pdvu_pkg.sv =====
// ----------------------------------------------------------------------------
// pdvu_pkg
// Shared types and constants of the particle drag velocity update pipeline.
// ----------------------------------------------------------------------------
package pdvu_pkg;

	// Scale factors of the drag coefficient: 3*rho_gas*Cd over 8*rho_p*r
	localparam int unsigned DRAG_NUM_K = 3;
	localparam int unsigned DRAG_DEN_K = 8;

	// Control flags that ride with an item through the iterative section
	typedef struct packed {
		logic vld;      // stage holds an item
		logic clip;     // some earlier step clipped
		logic ax_neg;   // pressure term x is negative
		logic ay_neg;   // pressure term y is negative
		logic ax_dz;    // x divisor (particle density) is zero
		logic ay_dz;    // y divisor (particle density) is zero
		logic coef_dz;  // drag denominator is zero
		logic ax_nz;    // x dividend is nonzero
		logic ay_nz;    // y dividend is nonzero
		logic coef_nz;  // drag numerator is nonzero
	} pdvu_ctl_t;

endpackage

// ===== rtl/pdvu_in_if.sv =====
// ----------------------------------------------------------------------------
// pdvu_in_if
// Particle channel: one beat carries one particle with its host cell values.
// ----------------------------------------------------------------------------
interface pdvu_in_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] part_vel_x;
	logic signed [DATA_WIDTH-1:0] part_vel_y;
	logic signed [DATA_WIDTH-1:0] gas_vel_x;
	logic signed [DATA_WIDTH-1:0] gas_vel_y;
	logic signed [DATA_WIDTH-1:0] press_grad_x;
	logic signed [DATA_WIDTH-1:0] press_grad_y;
	logic        [DATA_WIDTH-2:0] part_density;
	logic        [DATA_WIDTH-2:0] part_radius;
	logic        [DATA_WIDTH-2:0] drag_coeff;
	logic        [DATA_WIDTH-2:0] gas_density;

	modport source (
		output valid, part_vel_x, part_vel_y, gas_vel_x, gas_vel_y,
		output press_grad_x, press_grad_y, part_density, part_radius,
		output drag_coeff, gas_density,
		input  ready
	);

	modport sink (
		input  valid, part_vel_x, part_vel_y, gas_vel_x, gas_vel_y,
		input  press_grad_x, press_grad_y, part_density, part_radius,
		input  drag_coeff, gas_density,
		output ready
	);
endinterface

// ===== rtl/pdvu_out_if.sv =====
// ----------------------------------------------------------------------------
// pdvu_out_if
// Result channel: one beat carries the updated velocity of one particle.
// ----------------------------------------------------------------------------
interface pdvu_out_if #(
	parameter int DATA_WIDTH = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] new_vel_x;
	logic signed [DATA_WIDTH-1:0] new_vel_y;
	logic                         saturated;

	modport source (
		output valid, new_vel_x, new_vel_y, saturated,
		input  ready
	);

	modport sink (
		input  valid, new_vel_x, new_vel_y, saturated,
		output ready
	);
endinterface

// ===== rtl/pdvu_iter_core.sv =====
// ----------------------------------------------------------------------------
// pdvu_iter_core
// Pipelined restoring dividers (three lanes) and digit-by-digit square root,
// one quotient bit per stage and one root bit per stage for DATA_WIDTH stages.
// ----------------------------------------------------------------------------
module pdvu_iter_core #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                adv,
	input  pdvu_pkg::pdvu_ctl_t                 ctl_i,
	input  logic [DATA_WIDTH+FRAC_BITS-1:0]     ax_num_i,
	input  logic [DATA_WIDTH+FRAC_BITS-1:0]     ay_num_i,
	input  logic [DATA_WIDTH+FRAC_BITS-1:0]     coef_num_i,
	input  logic [DATA_WIDTH-2:0]               rho_i,
	input  logic [DATA_WIDTH-2:0]               den_i,
	input  logic [2*DATA_WIDTH-1:0]             sum_i,
	input  logic [4*DATA_WIDTH-1:0]             ctx_i,
	output pdvu_pkg::pdvu_ctl_t                 ctl_o,
	output logic [DATA_WIDTH+FRAC_BITS-1:0]     ax_quo_o,
	output logic [DATA_WIDTH+FRAC_BITS-1:0]     ay_quo_o,
	output logic [DATA_WIDTH+FRAC_BITS-1:0]     coef_quo_o,
	output logic [DATA_WIDTH-1:0]               root_o,
	output logic [4*DATA_WIDTH-1:0]             ctx_o
);
	localparam int W  = DATA_WIDTH;
	localparam int NB = DATA_WIDTH + FRAC_BITS;
	localparam int DB = DATA_WIDTH - 1;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	// The dividend and quotient share one shift register.
	function automatic logic [NB+DB-1:0] div_step(
		input logic [NB-1:0] xq,
		input logic [DB-1:0] rem,
		input logic [DB-1:0] d
	);
		logic [DB:0] r;
		logic        ge;
		r  = {rem, xq[NB-1]};
		ge = (r >= {1'b0, d});
		if (ge) begin
			r = r - {1'b0, d};
		end
		return {xq[NB-2:0], ge, r[DB-1:0]};
	endfunction

	// One root bit: bring down two radicand bits, try root*4+1.
	function automatic logic [4*W:0] sqrt_step(
		input logic [2*W-1:0] x,
		input logic [W-1:0]   root,
		input logic [W:0]     rem
	);
		logic [W+2:0] r;
		logic [W+2:0] t;
		logic         ge;
		r  = {rem, x[2*W-1:2*W-2]};
		t  = {1'b0, root, 2'b01};
		ge = (r >= t);
		if (ge) begin
			r = r - t;
		end
		return {x[2*W-3:0], 2'b00, root[W-2:0], ge, r[W:0]};
	endfunction

	pdvu_pkg::pdvu_ctl_t ctl_s    [NB];
	logic [NB-1:0]       ax_s     [NB];
	logic [DB-1:0]       ax_rem_s [NB];
	logic [NB-1:0]       ay_s     [NB];
	logic [DB-1:0]       ay_rem_s [NB];
	logic [NB-1:0]       cf_s     [NB];
	logic [DB-1:0]       cf_rem_s [NB];
	logic [DB-1:0]       rho_s    [NB];
	logic [DB-1:0]       den_s    [NB];
	logic [2*W-1:0]      sq_s     [NB];
	logic [W-1:0]        root_s   [NB];
	logic [W:0]          sq_rem_s [NB];
	logic [4*W-1:0]      ctx_s    [NB];

	for (genvar k = 0; k < NB; k++) begin : g_stage
		pdvu_pkg::pdvu_ctl_t ctl_in;
		logic [NB-1:0]       ax_in, ay_in, cf_in;
		logic [DB-1:0]       ax_rem_in, ay_rem_in, cf_rem_in, rho_in, den_in;
		logic [2*W-1:0]      sq_in;
		logic [W-1:0]        root_in;
		logic [W:0]          sq_rem_in;
		logic [4*W-1:0]      ctx_in;
		logic [NB-1:0]       ax_nx, ay_nx, cf_nx;
		logic [DB-1:0]       ax_rem_nx, ay_rem_nx, cf_rem_nx;
		logic [2*W-1:0]      sq_nx;
		logic [W-1:0]        root_nx;
		logic [W:0]          sq_rem_nx;

		if (k == 0) begin : g_first
			assign ctl_in    = ctl_i;
			assign ax_in     = ax_num_i;
			assign ay_in     = ay_num_i;
			assign cf_in     = coef_num_i;
			assign ax_rem_in = '0;
			assign ay_rem_in = '0;
			assign cf_rem_in = '0;
			assign rho_in    = rho_i;
			assign den_in    = den_i;
			assign sq_in     = sum_i;
			assign root_in   = '0;
			assign sq_rem_in = '0;
			assign ctx_in    = ctx_i;
		end else begin : g_next
			assign ctl_in    = ctl_s[k-1];
			assign ax_in     = ax_s[k-1];
			assign ay_in     = ay_s[k-1];
			assign cf_in     = cf_s[k-1];
			assign ax_rem_in = ax_rem_s[k-1];
			assign ay_rem_in = ay_rem_s[k-1];
			assign cf_rem_in = cf_rem_s[k-1];
			assign rho_in    = rho_s[k-1];
			assign den_in    = den_s[k-1];
			assign sq_in     = sq_s[k-1];
			assign root_in   = root_s[k-1];
			assign sq_rem_in = sq_rem_s[k-1];
			assign ctx_in    = ctx_s[k-1];
		end

		assign {ax_nx, ax_rem_nx} = div_step(ax_in, ax_rem_in, rho_in);
		assign {ay_nx, ay_rem_nx} = div_step(ay_in, ay_rem_in, rho_in);
		assign {cf_nx, cf_rem_nx} = div_step(cf_in, cf_rem_in, den_in);

		// Root is complete after W steps; hold it for the remaining stages
		if (k < W) begin : g_sqrt
			assign {sq_nx, root_nx, sq_rem_nx} = sqrt_step(sq_in, root_in, sq_rem_in);
		end else begin : g_hold
			assign sq_nx     = sq_in;
			assign root_nx   = root_in;
			assign sq_rem_nx = sq_rem_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[k] <= '0;
			end else if (adv) begin
				ctl_s[k] <= ctl_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ax_s[k]     <= ax_nx;
				ay_s[k]     <= ay_nx;
				cf_s[k]     <= cf_nx;
				ax_rem_s[k] <= ax_rem_nx;
				ay_rem_s[k] <= ay_rem_nx;
				cf_rem_s[k] <= cf_rem_nx;
				rho_s[k]    <= rho_in;
				den_s[k]    <= den_in;
				sq_s[k]     <= sq_nx;
				root_s[k]   <= root_nx;
				sq_rem_s[k] <= sq_rem_nx;
				ctx_s[k]    <= ctx_in;
			end
		end
	end

	assign ctl_o      = ctl_s[NB-1];
	assign ax_quo_o   = ax_s[NB-1];
	assign ay_quo_o   = ay_s[NB-1];
	assign coef_quo_o = cf_s[NB-1];
	assign root_o     = root_s[NB-1];
	assign ctx_o      = ctx_s[NB-1];

endmodule

// ===== rtl/particle_drag_velocity_update.sv =====
// ----------------------------------------------------------------------------
// particle_drag_velocity_update
// Explicit pressure-gradient and drag velocity update of one particle a beat.
// ----------------------------------------------------------------------------
// The block takes one particle per clock while not stalled and returns its
// updated velocity in order, one result per particle. Three stages form the
// differences, the pressure and coefficient products and the squared slip
// speed; the next DATA_WIDTH + FRAC_BITS stages run three restoring dividers
// and the square root one bit a stage; eight stages finish the drag products
// and the final subtraction. The whole pipeline advances together: it stalls
// only while the output register holds a result that is not taken, and then
// takes a new particle in the same cycle that result leaves. Program time_step
// while no particle is in flight. saturated flags a clip in any step of that
// particle's computation.
// ----------------------------------------------------------------------------
module particle_drag_velocity_update #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [DATA_WIDTH-2:0] cfg_wdata,
	pdvu_in_if.sink               particle,
	pdvu_out_if.source            result
);
	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int NB = DATA_WIDTH + FRAC_BITS;
	localparam int PW = 2 * DATA_WIDTH;
	// Magnitude width wide enough for any product, quotient or difference
	localparam int MW = ((PW > NB) ? PW : NB) + 1;
	localparam logic [MW-1:0] POS_LIM = {{(MW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [MW-1:0] NEG_LIM = POS_LIM + 1'b1;

	// Absolute value; the most negative code maps to its exact magnitude
	function automatic logic [W-1:0] mag(input logic [W-1:0] a);
		return a[W-1] ? (~a + 1'b1) : a;
	endfunction

	// Apply a sign to a magnitude and clip to the signed range: {clip, value}
	function automatic logic [W:0] fix(input logic neg, input logic [MW-1:0] m);
		logic [MW-1:0] lim;
		logic [MW-1:0] v;
		logic [W-1:0]  r;
		logic          c;
		lim = neg ? NEG_LIM : POS_LIM;
		c   = (m > lim);
		v   = c ? lim : m;
		r   = neg ? (~v[W-1:0] + 1'b1) : v[W-1:0];
		return {c, r};
	endfunction

	// Saturating a - b: {clip, value}
	function automatic logic [W:0] sub_sat(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0]   d;
		logic [W-1:0] r;
		logic         ovf;
		d   = {a[W-1], a} - {b[W-1], b};
		ovf = (d[W] != d[W-1]);
		r   = ovf ? {d[W], {(W-1){~d[W]}}} : d[W-1:0];
		return {ovf, r};
	endfunction

	logic          adv;
	logic [W-2:0]  time_step_q;

	// Time step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= '0;
		end else if (cfg_we) begin
			time_step_q <= cfg_wdata;
		end
	end

	// Advance everything unless a finished result is held back
	assign adv            = !result.valid || result.ready;
	assign particle.ready = adv;

	// ---------------- stage 1: slip velocity, pressure products, scaling ----
	logic          vld_s1, clip_s1;
	logic [W-1:0]  pvx_s1, pvy_s1, dvx_s1, dvy_s1;
	logic [PW-1:0] ppx_s1, ppy_s1;
	logic          pxneg_s1, pyneg_s1;
	logic [W-2:0]  n3_s1, d8_s1, rho_s1, rad_s1, cd_s1;
	logic [W-1:0]  dvx_d1, dvy_d1, n3_d1, d8_d1;
	logic          c_dvx1, c_dvy1, c_n31, c_d81;

	always_comb begin
		{c_dvx1, dvx_d1} = sub_sat(particle.part_vel_x, particle.gas_vel_x);
		{c_dvy1, dvy_d1} = sub_sat(particle.part_vel_y, particle.gas_vel_y);
		{c_n31, n3_d1}   = fix(1'b0, MW'(particle.gas_density) * MW'(pdvu_pkg::DRAG_NUM_K));
		{c_d81, d8_d1}   = fix(1'b0, MW'(particle.part_density) * MW'(pdvu_pkg::DRAG_DEN_K));
	end

	// ---------------- stage 2: pressure terms, coefficient products, squares
	logic          vld_s2, clip_s2;
	logic [W-1:0]  pvx_s2, pvy_s2, dvx_s2, dvy_s2, axn_s2, ayn_s2;
	logic [PW-1:0] nump_s2, denp_s2, sqx_s2, sqy_s2;
	logic [W-2:0]  rho_s2;
	logic [W-1:0]  axn_d2, ayn_d2;
	logic          c_ax2, c_ay2;

	always_comb begin
		{c_ax2, axn_d2} = fix(pxneg_s1, MW'(ppx_s1 >> F));
		{c_ay2, ayn_d2} = fix(pyneg_s1, MW'(ppy_s1 >> F));
	end

	// ---------------- stage 3: coefficient ratio operands, slip speed square
	pdvu_pkg::pdvu_ctl_t  ctl_s3;
	logic [NB-1:0]        axq_s3, ayq_s3, cfq_s3;
	logic [W-2:0]         rho_s3, den_s3;
	logic [PW-1:0]        sum_s3;
	logic [4*W-1:0]       ctx_s3;
	logic [W-1:0]         num_d3, den_d3;
	logic                 c_num3, c_den3;

	always_comb begin
		{c_num3, num_d3} = fix(1'b0, MW'(nump_s2 >> F));
		{c_den3, den_d3} = fix(1'b0, MW'(denp_s2 >> F));
	end

	// ---------------- iterative section ----------------
	pdvu_pkg::pdvu_ctl_t  ctl_c;
	logic [NB-1:0]        axq_c, ayq_c, cfq_c;
	logic [W-1:0]         root_c;
	logic [4*W-1:0]       ctx_c;

	pdvu_iter_core #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_iter (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ctl_i      (ctl_s3),
		.ax_num_i   (axq_s3),
		.ay_num_i   (ayq_s3),
		.coef_num_i (cfq_s3),
		.rho_i      (rho_s3),
		.den_i      (den_s3),
		.sum_i      (sum_s3),
		.ctx_i      (ctx_s3),
		.ctl_o      (ctl_c),
		.ax_quo_o   (axq_c),
		.ay_quo_o   (ayq_c),
		.coef_quo_o (cfq_c),
		.root_o     (root_c),
		.ctx_o      (ctx_c)
	);

	// ---------------- stage 4: clip quotients and speed ----------------
	logic          vld_s4, clip_s4;
	logic [W-1:0]  ax_s4, ay_s4, coef_s4, speed_s4, pvx_s4, pvy_s4, dvx_s4, dvy_s4;
	logic [W-1:0]  ax_d4, ay_d4, coef_d4, speed_d4;
	logic          c_ax4, c_ay4, c_cf4, c_sp4;
	logic [MW-1:0] axm_d4, aym_d4, cfm_d4;

	always_comb begin
		// A zero divisor gives zero for a zero dividend, else the signed bound
		axm_d4 = ctl_c.ax_dz ? (ctl_c.ax_nz ? '1 : '0) : MW'(axq_c);
		aym_d4 = ctl_c.ay_dz ? (ctl_c.ay_nz ? '1 : '0) : MW'(ayq_c);
		cfm_d4 = ctl_c.coef_dz ? (ctl_c.coef_nz ? '1 : '0) : MW'(cfq_c);
		{c_ax4, ax_d4}    = fix(ctl_c.ax_neg, axm_d4);
		{c_ay4, ay_d4}    = fix(ctl_c.ay_neg, aym_d4);
		{c_cf4, coef_d4}  = fix(1'b0, cfm_d4);
		{c_sp4, speed_d4} = fix(1'b0, MW'(root_c));
	end

	// ---------------- stage 5: pressure step, drag product ----------------
	logic          vld_s5, clip_s5;
	logic [W-1:0]  v1x_s5, v1y_s5, dvx_s5, dvy_s5;
	logic [PW-1:0] dragp_s5;
	logic [W-1:0]  v1x_d5, v1y_d5;
	logic          c_v1x5, c_v1y5;

	always_comb begin
		{c_v1x5, v1x_d5} = sub_sat(pvx_s4, ax_s4);
		{c_v1y5, v1y_d5} = sub_sat(pvy_s4, ay_s4);
	end

	// ---------------- stage 6: drag factor ----------------
	logic          vld_s6, clip_s6;
	logic [W-1:0]  v1x_s6, v1y_s6, dvx_s6, dvy_s6, drag_s6;
	logic [W-1:0]  drag_d6;
	logic          c_dr6;

	always_comb begin
		{c_dr6, drag_d6} = fix(1'b0, MW'(dragp_s5 >> F));
	end

	// ---------------- stage 7: drag times slip ----------------
	logic          vld_s7, clip_s7;
	logic [W-1:0]  v1x_s7, v1y_s7;
	logic [PW-1:0] tpx_s7, tpy_s7;
	logic          negx_s7, negy_s7;

	// ---------------- stage 8: clip drag acceleration ----------------
	logic          vld_s8, clip_s8;
	logic [W-1:0]  v1x_s8, v1y_s8, t1x_s8, t1y_s8;
	logic [W-1:0]  t1x_d8, t1y_d8;
	logic          c_t1x8, c_t1y8;

	always_comb begin
		{c_t1x8, t1x_d8} = fix(negx_s7, MW'(tpx_s7 >> F));
		{c_t1y8, t1y_d8} = fix(negy_s7, MW'(tpy_s7 >> F));
	end

	// ---------------- stage 9: times the time step ----------------
	logic          vld_s9, clip_s9;
	logic [W-1:0]  v1x_s9, v1y_s9;
	logic [PW-1:0] tpx_s9, tpy_s9;
	logic          negx_s9, negy_s9;

	// ---------------- stage 10: clip velocity change ----------------
	logic          vld_s10, clip_s10;
	logic [W-1:0]  v1x_s10, v1y_s10, tx_s10, ty_s10;
	logic [W-1:0]  tx_d10, ty_d10;
	logic          c_tx10, c_ty10;

	always_comb begin
		{c_tx10, tx_d10} = fix(negx_s9, MW'(tpx_s9 >> F));
		{c_ty10, ty_d10} = fix(negy_s9, MW'(tpy_s9 >> F));
	end

	// ---------------- stage 11: output register ----------------
	logic          vld_s11, clip_s11;
	logic [W-1:0]  nx_s11, ny_s11;
	logic [W-1:0]  nx_d11, ny_d11;
	logic          c_nx11, c_ny11;

	always_comb begin
		{c_nx11, nx_d11} = sub_sat(v1x_s10, tx_s10);
		{c_ny11, ny_d11} = sub_sat(v1y_s10, ty_s10);
	end

	// Valid bits travel with the data; stage 3 carries its bit in ctl_s3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= particle.valid;
			vld_s2  <= vld_s1;
			vld_s4  <= ctl_c.vld;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	// Datapath registers; hold on stall
	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1
			pvx_s1   <= particle.part_vel_x;
			pvy_s1   <= particle.part_vel_y;
			dvx_s1   <= dvx_d1;
			dvy_s1   <= dvy_d1;
			ppx_s1   <= PW'(mag(particle.press_grad_x)) * PW'(time_step_q);
			ppy_s1   <= PW'(mag(particle.press_grad_y)) * PW'(time_step_q);
			pxneg_s1 <= particle.press_grad_x[W-1];
			pyneg_s1 <= particle.press_grad_y[W-1];
			n3_s1    <= n3_d1[W-2:0];
			d8_s1    <= d8_d1[W-2:0];
			rho_s1   <= particle.part_density;
			rad_s1   <= particle.part_radius;
			cd_s1    <= particle.drag_coeff;
			clip_s1  <= c_dvx1 | c_dvy1 | c_n31 | c_d81;
			// stage 2
			pvx_s2   <= pvx_s1;
			pvy_s2   <= pvy_s1;
			dvx_s2   <= dvx_s1;
			dvy_s2   <= dvy_s1;
			axn_s2   <= axn_d2;
			ayn_s2   <= ayn_d2;
			nump_s2  <= PW'(n3_s1) * PW'(cd_s1);
			denp_s2  <= PW'(d8_s1) * PW'(rad_s1);
			sqx_s2   <= PW'(mag(dvx_s1)) * PW'(mag(dvx_s1));
			sqy_s2   <= PW'(mag(dvy_s1)) * PW'(mag(dvy_s1));
			rho_s2   <= rho_s1;
			clip_s2  <= clip_s1 | c_ax2 | c_ay2;
			// stage 3: operands of the dividers and the root
			axq_s3   <= {mag(axn_s2), {F{1'b0}}};
			ayq_s3   <= {mag(ayn_s2), {F{1'b0}}};
			cfq_s3   <= {1'b0, num_d3[W-2:0], {F{1'b0}}};
			rho_s3   <= rho_s2;
			den_s3   <= den_d3[W-2:0];
			sum_s3   <= sqx_s2 + sqy_s2;
			ctx_s3   <= {pvx_s2, pvy_s2, dvx_s2, dvy_s2};
			// stage 4
			ax_s4    <= ax_d4;
			ay_s4    <= ay_d4;
			coef_s4  <= coef_d4;
			speed_s4 <= speed_d4;
			{pvx_s4, pvy_s4, dvx_s4, dvy_s4} <= ctx_c;
			clip_s4  <= ctl_c.clip | c_ax4 | c_ay4 | c_cf4 | c_sp4;
			// stage 5
			v1x_s5   <= v1x_d5;
			v1y_s5   <= v1y_d5;
			dvx_s5   <= dvx_s4;
			dvy_s5   <= dvy_s4;
			dragp_s5 <= PW'(coef_s4[W-2:0]) * PW'(speed_s4[W-2:0]);
			clip_s5  <= clip_s4 | c_v1x5 | c_v1y5;
			// stage 6
			v1x_s6   <= v1x_s5;
			v1y_s6   <= v1y_s5;
			dvx_s6   <= dvx_s5;
			dvy_s6   <= dvy_s5;
			drag_s6  <= drag_d6;
			clip_s6  <= clip_s5 | c_dr6;
			// stage 7
			v1x_s7   <= v1x_s6;
			v1y_s7   <= v1y_s6;
			tpx_s7   <= PW'(drag_s6[W-2:0]) * PW'(mag(dvx_s6));
			tpy_s7   <= PW'(drag_s6[W-2:0]) * PW'(mag(dvy_s6));
			negx_s7  <= dvx_s6[W-1];
			negy_s7  <= dvy_s6[W-1];
			clip_s7  <= clip_s6;
			// stage 8
			v1x_s8   <= v1x_s7;
			v1y_s8   <= v1y_s7;
			t1x_s8   <= t1x_d8;
			t1y_s8   <= t1y_d8;
			clip_s8  <= clip_s7 | c_t1x8 | c_t1y8;
			// stage 9
			v1x_s9   <= v1x_s8;
			v1y_s9   <= v1y_s8;
			tpx_s9   <= PW'(mag(t1x_s8)) * PW'(time_step_q);
			tpy_s9   <= PW'(mag(t1y_s8)) * PW'(time_step_q);
			negx_s9  <= t1x_s8[W-1];
			negy_s9  <= t1y_s8[W-1];
			clip_s9  <= clip_s8;
			// stage 10
			v1x_s10  <= v1x_s9;
			v1y_s10  <= v1y_s9;
			tx_s10   <= tx_d10;
			ty_s10   <= ty_d10;
			clip_s10 <= clip_s9 | c_tx10 | c_ty10;
			// stage 11
			nx_s11   <= nx_d11;
			ny_s11   <= ny_d11;
			clip_s11 <= clip_s10 | c_nx11 | c_ny11;
		end
	end

	// Flags that ride through the iterative section
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s3.vld     <= vld_s2;
			ctl_s3.clip    <= clip_s2 | c_num3 | c_den3;
			ctl_s3.ax_neg  <= axn_s2[W-1];
			ctl_s3.ay_neg  <= ayn_s2[W-1];
			ctl_s3.ax_dz   <= (rho_s2 == '0);
			ctl_s3.ay_dz   <= (rho_s2 == '0);
			ctl_s3.coef_dz <= (den_d3 == '0);
			ctl_s3.ax_nz   <= (axn_s2 != '0);
			ctl_s3.ay_nz   <= (ayn_s2 != '0);
			ctl_s3.coef_nz <= (num_d3 != '0);
		end
	end

	assign result.valid     = vld_s11;
	assign result.new_vel_x = nx_s11;
	assign result.new_vel_y = ny_s11;
	assign result.saturated = clip_s11;

endmodule

// ===== rtl/pdvu_checker.sv =====
// ----------------------------------------------------------------------------
// pdvu_checker
// Port-level checks of the velocity update pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module pdvu_checker #(
	parameter int DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DATA_WIDTH-1:0] new_vel_x,
	input logic [DATA_WIDTH-1:0] new_vel_y,
	input logic                  saturated
);
	// A stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_vel_x) &&
			$stable(new_vel_y) && $stable(saturated))
		else $error("result beat changed while stalled");

	// A blocked result stalls the input side
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("particle taken while pipeline is stalled");

	// An empty or draining output register never blocks the input
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("particle refused while pipeline can advance");

	// Leave reset with no result pending
	a_rst: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result valid right after reset");

endmodule

bind particle_drag_velocity_update pdvu_checker #(
	.DATA_WIDTH (DATA_WIDTH)
) u_pdvu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (particle.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.new_vel_x (result.new_vel_x),
	.new_vel_y (result.new_vel_y),
	.saturated (result.saturated)
);
